// ----- rtl/pcc_pkg.sv -----
// Package for the clamped PID controller: payload structs, config
// register codes and datapath widths. No dependencies.
`default_nettype none

package pcc_pkg;

  // Datapath widths
  localparam int DataW    = 16;
  localparam int ErrW     = 17;
  localparam int SumW     = 32;
  localparam int DiffW    = 18;
  localparam int PropW    = DataW + ErrW;   // kp * err
  localparam int IntW     = DataW + SumW;   // ki_dt * sum
  localparam int DerW     = DataW + DiffW;  // kd_over_dt * diff
  localparam int AccW     = IntW + 2;       // sum of three products
  localparam int FracW    = 8;              // Q8.8 gains
  localparam int ShiftedW = AccW - FracW;
  localparam int CfgIdxW  = 3;

  // Default depth of the queue between front and back
  localparam int DEF_QUEUE_DEPTH = 4;

  // Config register indexes
  localparam logic [CfgIdxW-1:0] CFG_KP         = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KI_DT      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KD_OVER_DT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OUT_MAX    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OUT_MIN    = 3'd4;

  typedef struct packed {
    logic signed [DataW-1:0] setpoint;
    logic signed [DataW-1:0] measured;
  } sample_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    clamped;
  } result_t;

  // Work item handed from front to back
  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [SumW-1:0]  sum;
    logic signed [DiffW-1:0] diff;
  } work_t;

  typedef struct packed {
    logic signed [DataW-1:0] kp;
    logic signed [DataW-1:0] ki_dt;
    logic signed [DataW-1:0] kd_over_dt;
    logic signed [DataW-1:0] out_max;
    logic signed [DataW-1:0] out_min;
  } cfg_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

// ----- rtl/pcc_queue.sv -----
// Small register FIFO between the front and back of the PID controller.
// Depends on pcc_pkg (work_t, qstat_t).
`default_nettype none

module pcc_queue import pcc_pkg::*; #(
  parameter int Depth = DEF_QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire work_t  push_data,
  input  wire logic   pop,
  output work_t       head,
  output qstat_t      status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  work_t             mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign status.full  = (count == CntW'(Depth));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pcc_front.sv -----
// Front of the PID controller: accepts samples, forms the error, the
// saturated running sum and the error difference. Depends on pcc_pkg.
`default_nettype none

module pcc_front import pcc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  input  wire sample_t sample,
  input  wire qstat_t  q_status,
  output logic         push,
  output work_t        push_data
);

  logic signed [SumW-1:0] error_sum;
  logic signed [ErrW-1:0] last_error;

  logic signed [ErrW-1:0] err;
  logic signed [SumW:0]   sum_wide;
  logic signed [SumW-1:0] sum_sat;

  assign push = sample_valid && !q_status.full;

  // Error and saturating sum
  always_comb begin
    err      = ErrW'(sample.setpoint) - ErrW'(sample.measured);
    sum_wide = (SumW + 1)'(error_sum) + (SumW + 1)'(err);
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  assign push_data.err  = err;
  assign push_data.sum  = sum_sat;
  assign push_data.diff = DiffW'(err) - DiffW'(last_error);

  // Controller state advances on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (push) begin
      error_sum  <= sum_sat;
      last_error <= err;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pcc_back.sv -----
// Back of the PID controller: three gain products, their sum, shift and
// clamp, then the output register. Depends on pcc_pkg.
`default_nettype none

module pcc_back import pcc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire qstat_t  q_status,
  input  wire work_t   q_head,
  output logic         pop,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic                    adv;
  logic                    m_valid;
  logic                    a_valid;
  logic signed [PropW-1:0] p_prop;
  logic signed [IntW-1:0]  p_int;
  logic signed [DerW-1:0]  p_der;
  logic signed [AccW-1:0]  acc;

  logic signed [ShiftedW-1:0] y;
  result_t                    res_next;

  // Whole pipe moves unless the output holds a stalled transaction
  assign adv = !(result_valid && result_stall);
  assign pop = adv && !q_status.empty;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid      <= 1'b0;
      a_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      m_valid      <= !q_status.empty;
      a_valid      <= m_valid;
      result_valid <= a_valid;
    end
  end

  // Stage 1: gain products
  always_ff @(posedge clk) begin
    if (adv) begin
      p_prop <= PropW'(cfg.kp) * PropW'(q_head.err);
      p_int  <= IntW'(cfg.ki_dt) * IntW'(q_head.sum);
      p_der  <= DerW'(cfg.kd_over_dt) * DerW'(q_head.diff);
    end
  end

  // Stage 2: sum of products
  always_ff @(posedge clk) begin
    if (adv) begin
      acc <= AccW'(p_prop) + AccW'(p_int) + AccW'(p_der);
    end
  end

  // Stage 3: floor shift by the Q8.8 fraction, clamp, upper limit first
  always_comb begin
    y = acc[AccW-1:FracW];
    res_next.clamped = 1'b0;
    res_next.drive   = y[DataW-1:0];
    if (y > ShiftedW'(cfg.out_max)) begin
      res_next.drive   = cfg.out_max;
      res_next.clamped = 1'b1;
    end else if (y < ShiftedW'(cfg.out_min)) begin
      res_next.drive   = cfg.out_min;
      res_next.clamped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pid_controller_clamped_unit.sv -----
// Top level of the clamped PID controller: config registers, front,
// queue and back. Depends on pcc_pkg, pcc_front, pcc_queue, pcc_back.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  sample   | sample_valid, sample_stall, sample | in
//  result   | result_valid, result_stall, result | out
//  config   | cfg_we, cfg_index, cfg_data        | in
//
// One transaction per cycle sustained while result_stall stays low; a result
// passes the queue slot, product registers, sum register and output register.
// The sum and last-error update in the front sets that rate.
// Reset (rst, synchronous) clears the sum, last error, queue and valids and
// loads the default gains and limits. A stalled result holds the back pipe;
// samples keep entering until the queue fills, then sample_stall rises.
`default_nettype none

module pid_controller_clamped_unit import pcc_pkg::*; #(
  parameter int QueueDepth = DEF_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sample_valid,
  output logic                    sample_stall,
  input  wire sample_t            sample,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output result_t                 result,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [DataW-1:0]   cfg_data
);

  cfg_t   cfg;
  qstat_t q_status;
  logic   push;
  logic   pop;
  work_t  push_data;
  work_t  q_head;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp         <= '0;
      cfg.ki_dt      <= '0;
      cfg.kd_over_dt <= '0;
      cfg.out_max    <= {1'b0, {(DataW-1){1'b1}}};
      cfg.out_min    <= {1'b1, {(DataW-1){1'b0}}};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KP:         cfg.kp         <= cfg_data;
        CFG_KI_DT:      cfg.ki_dt      <= cfg_data;
        CFG_KD_OVER_DT: cfg.kd_over_dt <= cfg_data;
        CFG_OUT_MAX:    cfg.out_max    <= cfg_data;
        CFG_OUT_MIN:    cfg.out_min    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign sample_stall = q_status.full;

  pcc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample       (sample),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  pcc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .status    (q_status)
  );

  pcc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_status     (q_status),
    .q_head       (q_head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
